// File: rtl/tile_damage_hash_tracker_unit_macros.svh
// ----------------------------------------------------------------------------
// Tile damage hash tracker assertion macros
// Shared assertion forms for the tracker RTL, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef TILE_DAMAGE_HASH_TRACKER_UNIT_MACROS_SVH
`define TILE_DAMAGE_HASH_TRACKER_UNIT_MACROS_SVH

// A property that holds on every edge outside reset.
`define TDHT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition that must be followed by another in the next cycle.
`define TDHT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/tdht_pkg.sv
// ----------------------------------------------------------------------------
// Tile damage hash tracker package
// Request and result types, codes and hash constants shared by the tracker.
// ----------------------------------------------------------------------------
package tdht_pkg;

	localparam logic [31:0] FNV_BASIS  = 32'd2166136261;
	localparam logic [31:0] HASH_MULT  = 32'd16777619;
	localparam logic [9:0]  CANVAS_RST = 10'd512;
	localparam int          MAX_OUT    = 64;

	typedef enum logic [1:0] {
		REQ_FRAME_START = 2'd0,
		REQ_CMD_BYTE    = 2'd1,
		REQ_CMD_END     = 2'd2,
		REQ_FRAME_END   = 2'd3
	} req_t;

	typedef enum logic {
		REG_CANVAS_WIDTH  = 1'b0,
		REG_CANVAS_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_FOLD_CHK,
		ST_FOLD_MUL,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_SCAN_FLUSH
	} state_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] data_byte;
		logic [8:0] rect_x;
		logic [8:0] rect_y;
		logic [9:0] rect_w;
		logic [9:0] rect_h;
		logic       full_redraw;
	} in_item_t;

	typedef struct packed {
		logic [5:0] cell_index;
		logic       dirty_valid;
		logic       last;
	} out_item_t;

endpackage

// File: rtl/tdht_fnv_step.sv
// ----------------------------------------------------------------------------
// FNV-1a byte step
// The shared hash unit: xor one byte into the hash, multiply by the prime.
// ----------------------------------------------------------------------------
module tdht_fnv_step (
	input  logic [31:0] hash_in,
	input  logic [7:0]  byte_in,
	output logic [31:0] hash_out
);
	import tdht_pkg::*;

	logic [31:0] mixed;

	assign mixed    = hash_in ^ {24'd0, byte_in};
	assign hash_out = 32'(mixed * HASH_MULT);

endmodule

// File: rtl/tdht_tile_count.sv
// ----------------------------------------------------------------------------
// Tile count
// Number of tiles along one canvas side: ceiling of pixels over the tile
// size, clamped to one and to the grid limit, by reciprocal multiplication.
// ----------------------------------------------------------------------------
module tdht_tile_count #(
	parameter int TILE_SIZE = 64,
	parameter int LIMIT     = 8
) (
	input  logic [9:0]                   pixels,
	output logic [$clog2(LIMIT + 1)-1:0] count
);
	import tdht_pkg::*;

	localparam int XW   = $clog2(1023 + TILE_SIZE);
	localparam int L    = $clog2(TILE_SIZE);
	localparam int SH   = XW + L;
	localparam int M    = ((1 << SH) + TILE_SIZE - 1) / TILE_SIZE;
	localparam int MW   = XW + 1;
	localparam int PRW  = XW + MW;
	localparam int QW   = PRW - SH;
	localparam int CNTW = $clog2(LIMIT + 1);

	logic [XW-1:0]  x;
	logic [PRW-1:0] prod;
	logic [QW-1:0]  q;

	// The rounded-up reciprocal is exact for every x below 2**XW.
	assign x    = XW'(pixels) + XW'(TILE_SIZE - 1);
	assign prod = PRW'(x) * PRW'(M);
	assign q    = prod[PRW-1:SH];

	always_comb begin
		if (q == '0) begin
			count = CNTW'(1);
		end else if (32'(q) > 32'(LIMIT)) begin
			count = CNTW'(LIMIT);
		end else begin
			count = CNTW'(q);
		end
	end

endmodule

// File: rtl/tile_damage_hash_tracker_unit.sv
// Requests: a command byte is folded into the command hash while idle. A frame start
// clears the current tile hashes, STORE = MAX_TILE_COLS * MAX_TILE_ROWS entries. A
// command end with an empty clipped rectangle only resets the command hash; else it walks
// the store and folds the command hash into each covered tile. A frame end compares every
// entry, flushes the last result and waits out any result stall. One request is taken at
// a time, the next held by item_stall until idle. After reset a clearing pass runs first.
// ----------------------------------------------------------------------------
// Tile damage hash tracker
// Hashes draw commands into per-tile FNV-1a hashes and reports changed tiles (all on a
// first frame or full redraw) at frame end, walking the tile memories under a sequencer.
// ----------------------------------------------------------------------------
`include "tile_damage_hash_tracker_unit_macros.svh"

module tile_damage_hash_tracker_unit #(
	parameter int MAX_TILE_COLS = 8,
	parameter int MAX_TILE_ROWS = 8,
	parameter int TILE_SIZE     = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  tdht_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_stall,
	output tdht_pkg::out_item_t result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import tdht_pkg::*;

	localparam int TILE_STORE = MAX_TILE_COLS * MAX_TILE_ROWS;
	localparam int AW         = (TILE_STORE > 1) ? $clog2(TILE_STORE) : 1;
	localparam int CCW        = (MAX_TILE_COLS > 1) ? $clog2(MAX_TILE_COLS) : 1;
	localparam int CNW        = $clog2(MAX_TILE_COLS + 1);
	localparam int RNW        = $clog2(MAX_TILE_ROWS + 1);
	localparam int MAX_GRID   = (MAX_TILE_COLS > MAX_TILE_ROWS) ? MAX_TILE_COLS : MAX_TILE_ROWS;
	localparam int PW         = $clog2((MAX_GRID + 1) * TILE_SIZE + 2048);
	localparam int COLS_RAW   = (512 + TILE_SIZE - 1) / TILE_SIZE;
	localparam int ROWS_RAW   = COLS_RAW;
	localparam int COLS_RST   = (COLS_RAW > MAX_TILE_COLS) ? MAX_TILE_COLS : COLS_RAW;
	localparam int ROWS_RST   = (ROWS_RAW > MAX_TILE_ROWS) ? MAX_TILE_ROWS : ROWS_RAW;
	localparam logic [PW-1:0] TS_P = PW'(TILE_SIZE);

	// Configuration
	logic [9:0]     canvas_width_q;
	logic [9:0]     canvas_height_q;
	logic [CNW-1:0] cols_q;
	logic [RNW-1:0] rows_q;
	logic [CNW-1:0] cols_new;
	logic [RNW-1:0] rows_new;
	logic           cfg_wr;

	// Sequencer and datapath
	state_t          state_q;
	state_t          state_d;
	logic [AW-1:0]   addr_q;
	logic [CCW-1:0]  cc_q;
	logic [RNW-1:0]  rr_q;
	logic [PW-1:0]   px_q;
	logic [PW-1:0]   py_q;
	logic            clr_prev_q;
	logic [1:0]      k_q;
	logic [31:0]     h_q;
	logic [31:0]     cmd_hash_q;
	logic            first_frame_q;
	logic            all_q;
	logic [10:0]     xpos_q;
	logic [10:0]     xend_q;
	logic [10:0]     ypos_q;
	logic [10:0]     yend_q;
	logic            pend_vld_q;
	logic [5:0]      pend_idx_q;
	logic            out_vld_q;
	out_item_t       out_q;

	// Tile memories
	logic [31:0] cur_mem  [TILE_STORE];
	logic [31:0] prev_mem [TILE_STORE];
	logic [31:0] rd_cur_q;
	logic [31:0] rd_prev_q;

	// Control strobes
	logic        accept;
	logic        out_free;
	logic        last_addr;
	logic        cc_last;
	logic        in_grid;
	logic        tile_cover;
	logic        examined;
	logic        scan_hit;
	logic [10:0] x_sum;
	logic [10:0] y_sum;
	logic [10:0] x_end;
	logic [10:0] y_end;
	logic        span_ok;
	logic        walk_clr;
	logic        walk_adv;
	logic        cur_we;
	logic [31:0] cur_wd;
	logic        prev_we;
	logic [31:0] prev_wd;
	logic        push;
	out_item_t   push_data;
	logic        cmd_ld;
	logic        cmd_rst;
	logic        pend_set;
	logic        pend_clr;
	logic [31:0] fnv_hash_in;
	logic [7:0]  fnv_byte_in;
	logic [31:0] fnv_out;

	// ------------------------------------------------------------------
	// Configuration port
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	tdht_tile_count #(
		.TILE_SIZE (TILE_SIZE),
		.LIMIT     (MAX_TILE_COLS)
	) u_cols (
		.pixels (pwdata[9:0]),
		.count  (cols_new)
	);

	tdht_tile_count #(
		.TILE_SIZE (TILE_SIZE),
		.LIMIT     (MAX_TILE_ROWS)
	) u_rows (
		.pixels (pwdata[9:0]),
		.count  (rows_new)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canvas_width_q  <= CANVAS_RST;
			canvas_height_q <= CANVAS_RST;
			cols_q          <= CNW'(COLS_RST);
			rows_q          <= RNW'(ROWS_RST);
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[2]))
				REG_CANVAS_WIDTH: begin
					canvas_width_q <= pwdata[9:0];
					cols_q         <= cols_new;
				end
				REG_CANVAS_HEIGHT: begin
					canvas_height_q <= pwdata[9:0];
					rows_q          <= rows_new;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_CANVAS_WIDTH:  prdata = {22'd0, canvas_width_q};
			REG_CANVAS_HEIGHT: prdata = {22'd0, canvas_height_q};
			default:           prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Shared hash unit
	// ------------------------------------------------------------------
	tdht_fnv_step u_fnv (
		.hash_in  (fnv_hash_in),
		.byte_in  (fnv_byte_in),
		.hash_out (fnv_out)
	);

	// ------------------------------------------------------------------
	// Walk decode
	// ------------------------------------------------------------------
	assign accept       = item_valid && !item_stall;
	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = out_vld_q;
	assign result       = out_q;
	assign out_free     = !out_vld_q || !result_stall;

	assign last_addr = (addr_q == AW'(TILE_STORE - 1));
	assign cc_last   = ((32'(cc_q) + 32'd1) == 32'(cols_q));
	assign in_grid   = (32'(rr_q) < 32'(rows_q));

	// A tile is covered when its pixel span overlaps the clipped bounds.
	assign tile_cover = in_grid
		&& (px_q < PW'(xend_q)) && ((px_q + TS_P) > PW'(xpos_q))
		&& (py_q < PW'(yend_q)) && ((py_q + TS_P) > PW'(ypos_q));

	assign examined = in_grid && (32'(addr_q) < 32'(MAX_OUT));
	assign scan_hit = examined && (all_q || (rd_cur_q != rd_prev_q));

	assign x_sum   = {2'd0, item.rect_x} + {1'b0, item.rect_w};
	assign y_sum   = {2'd0, item.rect_y} + {1'b0, item.rect_h};
	assign x_end   = (x_sum > {1'b0, canvas_width_q}) ? {1'b0, canvas_width_q} : x_sum;
	assign y_end   = (y_sum > {1'b0, canvas_height_q}) ? {1'b0, canvas_height_q} : y_sum;
	assign span_ok = (item.rect_w != '0) && ({2'd0, item.rect_x} < x_end)
		&& (item.rect_h != '0) && ({2'd0, item.rect_y} < y_end);

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		walk_clr    = 1'b0;
		walk_adv    = 1'b0;
		cur_we      = 1'b0;
		cur_wd      = FNV_BASIS;
		prev_we     = 1'b0;
		prev_wd     = FNV_BASIS;
		push        = 1'b0;
		push_data   = '0;
		cmd_ld      = 1'b0;
		cmd_rst     = 1'b0;
		pend_set    = 1'b0;
		pend_clr    = 1'b0;
		fnv_hash_in = cmd_hash_q;
		fnv_byte_in = item.data_byte;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (req_t'(item.req_type))
						REQ_FRAME_START: begin
							cmd_rst  = 1'b1;
							walk_clr = 1'b1;
							state_d  = ST_CLEAR;
						end
						REQ_CMD_BYTE: begin
							cmd_ld = 1'b1;
						end
						REQ_CMD_END: begin
							if (span_ok) begin
								walk_clr = 1'b1;
								state_d  = ST_FOLD_CHK;
							end else begin
								cmd_rst = 1'b1;
							end
						end
						REQ_FRAME_END: begin
							walk_clr = 1'b1;
							pend_clr = 1'b1;
							state_d  = ST_SCAN_RD;
						end
						default: begin
						end
					endcase
				end
			end
			ST_CLEAR: begin
				cur_we  = 1'b1;
				prev_we = clr_prev_q;
				if (last_addr) begin
					state_d = ST_IDLE;
				end else begin
					walk_adv = 1'b1;
				end
			end
			ST_FOLD_CHK: begin
				if (tile_cover) begin
					state_d = ST_FOLD_MUL;
				end else if (last_addr) begin
					cmd_rst = 1'b1;
					state_d = ST_IDLE;
				end else begin
					walk_adv = 1'b1;
				end
			end
			ST_FOLD_MUL: begin
				// Four byte steps, lowest command hash byte first.
				fnv_hash_in = (k_q == 2'd0) ? rd_cur_q : h_q;
				fnv_byte_in = cmd_hash_q[{k_q, 3'b000} +: 8];
				if (k_q == 2'd3) begin
					cur_we = 1'b1;
					cur_wd = fnv_out;
					if (last_addr) begin
						cmd_rst = 1'b1;
						state_d = ST_IDLE;
					end else begin
						walk_adv = 1'b1;
						state_d  = ST_FOLD_CHK;
					end
				end
			end
			ST_SCAN_RD: begin
				state_d = ST_SCAN_CMP;
			end
			ST_SCAN_CMP: begin
				// The held tile goes out only once a later one proves it is not last.
				if (!(scan_hit && pend_vld_q && !out_free)) begin
					prev_we = 1'b1;
					prev_wd = rd_cur_q;
					if (scan_hit) begin
						pend_set = 1'b1;
						if (pend_vld_q) begin
							push      = 1'b1;
							push_data = '{cell_index: pend_idx_q, dirty_valid: 1'b1,
								last: 1'b0};
						end
					end
					if (last_addr) begin
						state_d = ST_SCAN_FLUSH;
					end else begin
						walk_adv = 1'b1;
						state_d  = ST_SCAN_RD;
					end
				end
			end
			ST_SCAN_FLUSH: begin
				if (out_free) begin
					push    = 1'b1;
					state_d = ST_IDLE;
					if (pend_vld_q) begin
						push_data = '{cell_index: pend_idx_q, dirty_valid: 1'b1, last: 1'b1};
					end else begin
						push_data = '{cell_index: 6'd0, dirty_valid: 1'b0, last: 1'b1};
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Tile walker
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			cc_q   <= '0;
			rr_q   <= '0;
			px_q   <= '0;
			py_q   <= '0;
		end else if (walk_clr) begin
			addr_q <= '0;
			cc_q   <= '0;
			rr_q   <= '0;
			px_q   <= '0;
			py_q   <= '0;
		end else if (walk_adv) begin
			addr_q <= addr_q + 1'b1;
			if (cc_last) begin
				cc_q <= '0;
				px_q <= '0;
				if (in_grid) begin
					rr_q <= rr_q + 1'b1;
					py_q <= py_q + TS_P;
				end
			end else begin
				cc_q <= cc_q + 1'b1;
				px_q <= px_q + TS_P;
			end
		end
	end

	// ------------------------------------------------------------------
	// Control state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_prev_q    <= 1'b1;
			k_q           <= 2'd0;
			cmd_hash_q    <= FNV_BASIS;
			first_frame_q <= 1'b1;
			pend_vld_q    <= 1'b0;
			out_vld_q     <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR && last_addr) begin
				clr_prev_q <= 1'b0;
			end
			if (state_q == ST_FOLD_MUL) begin
				k_q <= k_q + 2'd1;
			end
			if (cmd_rst) begin
				cmd_hash_q <= FNV_BASIS;
			end else if (cmd_ld) begin
				cmd_hash_q <= fnv_out;
			end
			if (accept && req_t'(item.req_type) == REQ_FRAME_END) begin
				first_frame_q <= 1'b0;
			end
			if (pend_clr) begin
				pend_vld_q <= 1'b0;
			end else if (pend_set) begin
				pend_vld_q <= 1'b1;
			end
			if (push) begin
				out_vld_q <= 1'b1;
			end else if (!result_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Payload registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (state_q == ST_FOLD_MUL) begin
			h_q <= fnv_out;
		end
		if (accept && req_t'(item.req_type) == REQ_CMD_END) begin
			xpos_q <= {2'd0, item.rect_x};
			xend_q <= x_end;
			ypos_q <= {2'd0, item.rect_y};
			yend_q <= y_end;
		end
		if (accept && req_t'(item.req_type) == REQ_FRAME_END) begin
			all_q <= first_frame_q || item.full_redraw;
		end
		if (pend_set) begin
			pend_idx_q <= 6'(addr_q);
		end
		if (push) begin
			out_q <= push_data;
		end
	end

	// ------------------------------------------------------------------
	// Tile memories: one write and one registered read each per cycle
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (cur_we) begin
			cur_mem[addr_q] <= cur_wd;
		end
		rd_cur_q <= cur_mem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (prev_we) begin
			prev_mem[addr_q] <= prev_wd;
		end
		rd_prev_q <= prev_mem[addr_q];
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`TDHT_ASSERT(a_push_slot_free, !push || out_free, "result overwritten before it was taken")
	`TDHT_ASSERT(a_empty_shape, !result_valid || result.dirty_valid || (result.last && result.cell_index == 6'd0), "no-change result malformed")
	`TDHT_ASSERT(a_rising_index, !(pend_vld_q && pend_set) || (32'(pend_idx_q) < 32'(addr_q)), "dirty tiles out of order")
	`TDHT_ASSERT_NEXT(a_last_ends_scan, push && push_data.last, state_q == ST_IDLE, "frame end did not finish after last result")
	`TDHT_ASSERT_NEXT(a_fold_resets_hash, state_q == ST_FOLD_MUL && k_q == 2'd3 && last_addr, cmd_hash_q == FNV_BASIS, "command hash not reset after fold")

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile damage hash tracker testbench
// Drives frame, command byte, command end and frame end requests into the
// tracker, mirrors the per-tile FNV-1a hashes in a local predictor, and checks
// every reported tile against the predicted dirty list in order.
// ----------------------------------------------------------------------------
module testbench;
	import tdht_pkg::*;

	localparam int COLS_MAX      = 8;
	localparam int ROWS_MAX      = 8;
	localparam int TILE_PX       = 64;
	localparam int TILE_COUNT    = COLS_MAX * ROWS_MAX;
	// Longest silent request is a command end covering every tile.
	localparam int SETTLE_CYCLES = 6 * TILE_COUNT + 16;
	localparam int RANDOM_ITEMS  = 320;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	in_item_t    item;
	logic        result_valid;
	logic        result_stall = 1'b0;
	out_item_t   result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Predictor state.
	logic [31:0] tile_sig [TILE_COUNT];
	logic [31:0] tile_sig_prev [TILE_COUNT];
	logic [31:0] cmd_sig;
	logic        first_frame_pending;
	logic [9:0]  canvas_w;
	logic [9:0]  canvas_h;

	out_item_t   pending_tiles [$];
	out_item_t   want;
	int          mismatches = 0;
	int          sent_count = 0;
	bit          idle_en = 1'b1;

	tile_damage_hash_tracker_unit #(
		.MAX_TILE_COLS(COLS_MAX),
		.MAX_TILE_ROWS(ROWS_MAX),
		.TILE_SIZE(TILE_PX)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic report(input string what, input int exp_val, input int act_val);
		mismatches++;
		if (mismatches <= 100)
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_val,
				act_val);
	endtask

	function automatic logic [31:0] fnv_mix(input logic [31:0] h, input logic [7:0] b);
		return (h ^ {24'd0, b}) * HASH_MULT;
	endfunction

	function automatic int unsigned tiles_along(input int unsigned pixels,
		input int unsigned limit);
		int unsigned n;
		n = (pixels + TILE_PX - 1) / TILE_PX;
		if (n < 1) n = 1;
		if (n > limit) n = limit;
		return n;
	endfunction

	function automatic bit tile_span(input int unsigned pos, input int unsigned len,
		input int unsigned extent, input int unsigned count,
		output int unsigned lo, output int unsigned hi);
		int unsigned end_px;
		end_px = pos + len;
		lo = 0;
		hi = 0;
		if (end_px > extent) end_px = extent;
		if (len == 0 || pos >= end_px) return 1'b0;
		lo = pos / TILE_PX;
		hi = (end_px - 1) / TILE_PX;
		if (lo >= count) return 1'b0;
		if (hi >= count) hi = count - 1;
		return 1'b1;
	endfunction

	function automatic void clear_tiles();
		for (int i = 0; i < TILE_COUNT; i++) tile_sig[i] = FNV_BASIS;
		cmd_sig = FNV_BASIS;
	endfunction

	function automatic void fold_command(input in_item_t it);
		int unsigned cols, rows, x0, x1, y0, y1, idx;
		bit hit_x, hit_y;
		logic [31:0] h;
		cols = tiles_along(32'(canvas_w), COLS_MAX);
		rows = tiles_along(32'(canvas_h), ROWS_MAX);
		hit_x = tile_span(32'(it.rect_x), 32'(it.rect_w), 32'(canvas_w), cols, x0, x1);
		hit_y = tile_span(32'(it.rect_y), 32'(it.rect_h), 32'(canvas_h), rows, y0, y1);
		if (hit_x && hit_y) begin
			for (int unsigned cy = y0; cy <= y1; cy++) begin
				for (int unsigned cx = x0; cx <= x1; cx++) begin
					idx = cy * cols + cx;
					if (idx < TILE_COUNT) begin
						h = tile_sig[idx];
						for (int k = 0; k < 4; k++) h = fnv_mix(h, cmd_sig[8*k +: 8]);
						tile_sig[idx] = h;
					end
				end
			end
		end
		cmd_sig = FNV_BASIS;
	endfunction

	function automatic void scan_dirty(input in_item_t it);
		int unsigned total;
		logic [63:0] dirty;
		int last_idx;
		bit report_all;
		out_item_t entry;
		total = tiles_along(32'(canvas_w), COLS_MAX) * tiles_along(32'(canvas_h), ROWS_MAX);
		if (total > MAX_OUT) total = MAX_OUT;
		if (total > TILE_COUNT) total = TILE_COUNT;
		report_all = first_frame_pending || it.full_redraw;
		dirty = '0;
		last_idx = -1;
		for (int i = 0; i < TILE_COUNT; i++) begin
			dirty[i] = (i < total) && (report_all || tile_sig[i] != tile_sig_prev[i]);
			if (dirty[i]) last_idx = i;
		end
		if (last_idx < 0) begin
			entry.cell_index = '0;
			entry.dirty_valid = 1'b0;
			entry.last = 1'b1;
			pending_tiles = {pending_tiles, entry};
		end else begin
			for (int i = 0; i < TILE_COUNT; i++) begin
				if (dirty[i]) begin
					entry.cell_index = 6'(i);
					entry.dirty_valid = 1'b1;
					entry.last = (i == last_idx);
					pending_tiles = {pending_tiles, entry};
				end
			end
		end
		for (int i = 0; i < TILE_COUNT; i++) tile_sig_prev[i] = tile_sig[i];
		first_frame_pending = 1'b0;
	endfunction

	function automatic void track_request(input in_item_t it);
		case (it.req_type)
			REQ_FRAME_START: clear_tiles();
			REQ_CMD_BYTE:    cmd_sig = fnv_mix(cmd_sig, it.data_byte);
			REQ_CMD_END:     fold_command(it);
			default:         scan_dirty(it);
		endcase
	endfunction

	// Result checker and receiver stall generator.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_tiles.size() == 0) begin
				mismatches++;
				if (mismatches <= 100)
					$display("%0t: unexpected result, expected none, actual cell %0d",
						$time, result.cell_index);
			end else begin
				want = pending_tiles.pop_front();
				if (result.cell_index !== want.cell_index)
					report("cell_index", int'(want.cell_index), int'(result.cell_index));
				if (result.dirty_valid !== want.dirty_valid)
					report("dirty_valid", int'(want.dirty_valid), int'(result.dirty_valid));
				if (result.last !== want.last)
					report("last", int'(want.last), int'(result.last));
			end
		end
		result_stall <= idle_en && ($urandom_range(99) < 6);
	end

	// Sends one request; returns at the edge where it was accepted.
	task automatic send_req(input in_item_t it);
		while (idle_en && $urandom_range(99) < 6) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		track_request(it);
		sent_count++;
	endtask

	function automatic in_item_t mk_req(input req_t kind, input logic [7:0] b,
		input logic [8:0] x, input logic [8:0] y, input logic [9:0] w,
		input logic [9:0] h, input logic redraw);
		in_item_t it;
		it.req_type = kind;
		it.data_byte = b;
		it.rect_x = x;
		it.rect_y = y;
		it.rect_w = w;
		it.rect_h = h;
		it.full_redraw = redraw;
		return it;
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		logic [48:0] raw;
		raw = 49'({$urandom, $urandom});
		it = raw;
		if (it.rect_w > 10'd512) it.rect_w = 10'($urandom_range(0, 512));
		if (it.rect_h > 10'd512) it.rect_h = 10'($urandom_range(0, 512));
		return it;
	endfunction

	function automatic logic [8:0] pick_pos();
		case ($urandom_range(0, 7))
			0:       return 9'd0;
			1:       return 9'd511;
			2:       return 9'($urandom_range(0, 7) * TILE_PX);
			3:       return 9'($urandom_range(1, 8) * TILE_PX - 1);
			default: return 9'($urandom_range(0, 511));
		endcase
	endfunction

	function automatic logic [9:0] pick_size();
		case ($urandom_range(0, 9))
			0:       return 10'd0;
			1:       return 10'd512;
			2:       return 10'($urandom_range(1, 512));
			default: return 10'($urandom_range(1, 150));
		endcase
	endfunction

	task automatic wait_drained();
		item_valid <= 1'b0;
		while (pending_tiles.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_xfer(input logic wr, input reg_idx_t r, input logic [31:0] wdata,
		output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {r, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t r, input logic [9:0] v);
		logic [31:0] rd;
		apb_xfer(1'b1, r, {22'd0, v}, rd);
		apb_xfer(1'b0, r, 32'd0, rd);
		if (rd[9:0] !== v) report("register readback", int'(v), int'(rd[9:0]));
		if (r == REG_CANVAS_WIDTH) canvas_w = v;
		else canvas_h = v;
	endtask

	task automatic set_canvas(input logic [9:0] w, input logic [9:0] h);
		wait_drained();
		write_reg(REG_CANVAS_WIDTH, w);
		write_reg(REG_CANVAS_HEIGHT, h);
	endtask

	// The first frame end reports every tile; a repeat with no change reports none.
	task automatic test_first_frame();
		send_req(mk_req(REQ_FRAME_END, 8'd0, 9'd0, 9'd0, 10'd0, 10'd0, 1'b0));
		send_req(mk_req(REQ_FRAME_END, 8'd0, 9'd0, 9'd0, 10'd0, 10'd0, 1'b0));
	endtask

	task automatic test_command_fold();
		send_req(mk_req(REQ_FRAME_START, 8'd0, 9'd0, 9'd0, 10'd0, 10'd0, 1'b0));
		send_req(mk_req(REQ_CMD_BYTE, 8'h00, 9'd0, 9'd0, 10'd0, 10'd0, 1'b0));
		send_req(mk_req(REQ_CMD_BYTE, 8'hFF, 9'd0, 9'd0, 10'd0, 10'd0, 1'b0));
		send_req(mk_req(REQ_CMD_END, 8'd0, 9'd0, 9'd0, 10'd1, 10'd1, 1'b0));
		send_req(mk_req(REQ_CMD_BYTE, 8'hA5, 9'd0, 9'd0, 10'd0, 10'd0, 1'b0));
		// Bounds that run past the canvas edge are clipped to the last tile.
		send_req(mk_req(REQ_CMD_END, 8'd0, 9'd511, 9'd511, 10'd512, 10'd512, 1'b0));
		send_req(mk_req(REQ_CMD_BYTE, 8'h3C, 9'd0, 9'd0, 10'd0, 10'd0, 1'b0));
		send_req(mk_req(REQ_CMD_END, 8'd0, 9'd0, 9'd0, 10'd512, 10'd512, 1'b0));
		send_req(mk_req(REQ_CMD_END, 8'd0, 9'd100, 9'd0, 10'd0, 10'd50, 1'b0));
		send_req(mk_req(REQ_CMD_END, 8'd0, 9'd0, 9'd100, 10'd50, 10'd0, 1'b0));
		send_req(mk_req(REQ_FRAME_END, 8'd0, 9'd0, 9'd0, 10'd0, 10'd0, 1'b0));
		wait_drained();
	endtask

	task automatic test_full_redraw();
		send_req(mk_req(REQ_FRAME_END, 8'd0, 9'd0, 9'd0, 10'd0, 10'd0, 1'b1));
		send_req(mk_req(REQ_FRAME_END, 8'd0, 9'd0, 9'd0, 10'd0, 10'd0, 1'b0));
	endtask

	task automatic test_canvas_settings();
		set_canvas(10'd1, 10'd1);
		send_req(mk_req(REQ_CMD_BYTE, 8'h11, 9'd0, 9'd0, 10'd0, 10'd0, 1'b0));
		send_req(mk_req(REQ_CMD_END, 8'd0, 9'd0, 9'd0, 10'd1, 10'd1, 1'b0));
		send_req(mk_req(REQ_FRAME_END, 8'd0, 9'd0, 9'd0, 10'd0, 10'd0, 1'b0));
		// Out-of-range sizes: zero width counts as one column, 1023 saturates.
		set_canvas(10'd0, 10'd1023);
		send_req(mk_req(REQ_CMD_BYTE, 8'h80, 9'd0, 9'd0, 10'd0, 10'd0, 1'b0));
		send_req(mk_req(REQ_CMD_END, 8'd0, 9'd0, 9'd0, 10'd512, 10'd512, 1'b0));
		send_req(mk_req(REQ_FRAME_END, 8'd0, 9'd0, 9'd0, 10'd0, 10'd0, 1'b0));
		set_canvas(10'd130, 10'd70);
		send_req(mk_req(REQ_CMD_END, 8'd0, 9'd200, 9'd0, 10'd10, 10'd10, 1'b0));
		send_req(mk_req(REQ_CMD_BYTE, 8'h7E, 9'd0, 9'd0, 10'd0, 10'd0, 1'b0));
		send_req(mk_req(REQ_CMD_END, 8'd0, 9'd120, 9'd60, 10'd200, 10'd200, 1'b0));
		send_req(mk_req(REQ_FRAME_END, 8'd0, 9'd0, 9'd0, 10'd0, 10'd0, 1'b0));
		set_canvas(10'd512, 10'd512);
	endtask

	task automatic random_frame();
		in_item_t it;
		int n_cmds;
		int n_bytes;
		if ($urandom_range(99) < 85) begin
			it = random_item();
			it.req_type = REQ_FRAME_START;
			send_req(it);
		end
		n_cmds = $urandom_range(0, 5);
		for (int c = 0; c < n_cmds; c++) begin
			n_bytes = $urandom_range(0, 6);
			for (int b = 0; b < n_bytes; b++) begin
				it = random_item();
				it.req_type = REQ_CMD_BYTE;
				send_req(it);
			end
			if ($urandom_range(99) < 10) send_req(random_item());
			it = random_item();
			it.req_type = REQ_CMD_END;
			it.rect_x = pick_pos();
			it.rect_y = pick_pos();
			it.rect_w = pick_size();
			it.rect_h = pick_size();
			send_req(it);
		end
		it = random_item();
		it.req_type = REQ_FRAME_END;
		it.full_redraw = ($urandom_range(99) < 10);
		send_req(it);
	endtask

	task automatic random_canvas();
		case ($urandom_range(0, 5))
			0: set_canvas(10'd512, 10'd512);
			1: set_canvas(10'd1, 10'd512);
			2: set_canvas(10'd64, 10'd65);
			3: set_canvas(10'd0, 10'd1023);
			default: set_canvas(10'($urandom_range(1, 512)), 10'($urandom_range(1, 512)));
		endcase
	endtask

	task automatic test_random_traffic();
		int first_item;
		int frame_no;
		first_item = sent_count;
		frame_no = 0;
		while (sent_count < first_item + RANDOM_ITEMS) begin
			// A long stretch with neither side idling.
			idle_en = !(sent_count >= first_item + 100 && sent_count < first_item + 200);
			if (frame_no % 6 == 5) random_canvas();
			else if (frame_no == 8) wait_drained();
			random_frame();
			frame_no++;
		end
		idle_en = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		canvas_w = CANVAS_RST;
		canvas_h = CANVAS_RST;
		clear_tiles();
		for (int i = 0; i < TILE_COUNT; i++) tile_sig_prev[i] = FNV_BASIS;
		first_frame_pending = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_first_frame();
		test_command_fold();
		test_full_redraw();
		test_canvas_settings();
		test_random_traffic();
		wait_drained();

		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
